// ----- design/assert_macros.svh -----
// ------------------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on aclk and quiet during reset.
// ------------------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/mas_pkg.sv -----
// ------------------------------------------------------------------------------------------
// Matrix add/sub/multiply package
// Shared constants, codes, word layouts and types of the matrix engine.
// ------------------------------------------------------------------------------------------
package mas_pkg;

    // sizing
    localparam int MAX_DIM     = 8;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int DIM_W       = 4;
    localparam int POS_W       = 3;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = PROD_W + $clog2(MAX_DIM + 1) + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int PADDR_W     = 5;

    // round half up on the product sum; nothing when there are no fraction bits
    localparam logic signed [ACC_W-1:0] ROUND_C = (ACC_W'(1) << FRAC_BITS) >> 1;
    localparam logic [DATA_W-1:0]        SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]        SAT_MIN = 32'h8000_0000;

    // input action codes
    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_BAD = 2'd3
    } op_t;

    // register map, index = paddr / 4
    typedef enum logic [2:0] {
        REG_OPERATION = 3'd0,
        REG_A_ROWS    = 3'd1,
        REG_A_COLS    = 3'd2,
        REG_B_ROWS    = 3'd3,
        REG_B_COLS    = 3'd4
    } reg_idx_t;

    // command kinds held in the queue
    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_RUN
    } cmd_kind_t;

    // engine sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT,
        ST_ERR
    } eng_state_t;

    // configuration as seen by front and engine
    typedef struct packed {
        op_t              operation;
        logic [DIM_W-1:0] a_rows;
        logic [DIM_W-1:0] a_cols;
        logic [DIM_W-1:0] b_rows;
        logic [DIM_W-1:0] b_cols;
    } cfg_t;

    // queued command
    typedef struct packed {
        cmd_kind_t         kind;
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } cmd_t;

    // input word, lowest field last
    typedef struct packed {
        logic [1:0]        pad;
        logic [DATA_W-1:0] element;
        logic [POS_W-1:0]  col_index;
        logic [POS_W-1:0]  row_index;
    } in_word_t;

    // result word, lowest field last
    typedef struct packed {
        logic [1:0]        pad;
        logic [DATA_W-1:0] out_value;
        logic [POS_W-1:0]  out_col;
        logic [POS_W-1:0]  out_row;
    } out_word_t;

    // dimension in 1..MAX_DIM
    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        logic in_range;
        in_range = ({1'b0, d} <= (DIM_W+1)'(MAX_DIM));
        return (d != '0) && in_range;
    endfunction

endpackage

// ----- design/mas_front.sv -----
// ------------------------------------------------------------------------------------------
// Matrix engine front end
// Takes input words, drops what means nothing, and queues loads and runs with their
// store address or dimension check.
// ------------------------------------------------------------------------------------------
module mas_front
    import mas_pkg::*;
(
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_word_t s_word,
    input  action_t  s_action,
    input  cfg_t     cfg,
    input  logic     q_ready,
    output logic     q_push,
    output cmd_t     q_wdata
);

    logic in_range;
    logic keep;
    logic run_ok;
    logic dims_ok;

    // words are taken whenever the queue has room
    assign s_tready = q_ready;

    // loads outside the store are dropped
    assign in_range = ({1'b0, s_word.row_index} < (POS_W+1)'(MAX_DIM))
                   && ({1'b0, s_word.col_index} < (POS_W+1)'(MAX_DIM));

    // run dimension check; the user keeps config stable while work is pending, not enforced
    assign dims_ok = dim_ok(cfg.a_rows) && dim_ok(cfg.a_cols)
                  && dim_ok(cfg.b_rows) && dim_ok(cfg.b_cols);

    always_comb begin
        case (cfg.operation)
            OP_ADD, OP_SUB: run_ok = dims_ok && (cfg.a_rows == cfg.b_rows)
                                             && (cfg.a_cols == cfg.b_cols);
            OP_MUL:         run_ok = dims_ok && (cfg.a_cols == cfg.b_rows);
            default:        run_ok = 1'b0;
        endcase
    end

    // classify and build the queued command
    always_comb begin
        q_wdata.kind = CMD_RUN;
        q_wdata.ok   = run_ok;
        q_wdata.addr = {IDX_W'(s_word.row_index), IDX_W'(s_word.col_index)};
        q_wdata.data = s_word.element;
        keep         = 1'b0;
        case (s_action)
            ACT_LOAD_A: begin
                q_wdata.kind = CMD_LOAD_A;
                keep         = in_range;
            end
            ACT_LOAD_B: begin
                q_wdata.kind = CMD_LOAD_B;
                keep         = in_range;
            end
            ACT_RUN: begin
                q_wdata.kind = CMD_RUN;
                keep         = 1'b1;
            end
            default: begin
                q_wdata.kind = CMD_RUN;
                keep         = 1'b0;
            end
        endcase
    end

    assign q_push = s_tvalid && q_ready && keep;

endmodule

// ----- design/mas_queue.sv -----
// ------------------------------------------------------------------------------------------
// Matrix engine command queue
// Short FIFO between front end and engine so each side stalls on its own.
// ------------------------------------------------------------------------------------------
module mas_queue
    import mas_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t wdata,
    output logic ready,
    output logic valid,
    output cmd_t rdata,
    input  logic pop
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/mas_engine.sv -----
// ------------------------------------------------------------------------------------------
// Matrix engine back end
// Holds both element stores, performs queued loads, and walks a run element by element
// through a read, multiply/add and accumulate pipeline into the result register.
// ------------------------------------------------------------------------------------------
module mas_engine
    import mas_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  cmd_t      q_data,
    output logic      q_pop,
    output logic      m_tvalid,
    input  logic      m_tready,
    output out_word_t m_word,
    output logic      m_error,
    output logic      m_last
);

    eng_state_t state_reg, state_next;

    logic [DATA_W-1:0] mem_a [STORE_DEPTH];
    logic [DATA_W-1:0] mem_b [STORE_DEPTH];
    logic [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic [ADDR_W-1:0] addr_a, addr_b;

    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] i_last, j_last, k_last;

    logic rd_vld_reg, rd_first_reg;
    logic mul_vld_reg, mul_first_reg;
    logic signed [PROD_W-1:0] term_reg, term_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic signed [DATA_W-1:0] a_s, b_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [DATA_W:0]   sum_s;
    logic signed [ACC_W-1:0]  rounded, scaled;
    logic [ACC_W-DATA_W:0]    top_bits;
    logic [DATA_W-1:0]        result;

    logic op_mul;
    logic issue, wr_a, wr_b, slot_free, out_load, elem_last;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg;
    logic      out_error_reg, out_last_reg;

    assign op_mul    = (cfg.operation == OP_MUL);
    assign slot_free = !out_valid_reg || m_tready;

    // loop bounds; dims were checked before the run started
    assign i_last    = IDX_W'(cfg.a_rows - DIM_W'(1));
    assign j_last    = op_mul ? IDX_W'(cfg.b_cols - DIM_W'(1)) : IDX_W'(cfg.a_cols - DIM_W'(1));
    assign k_last    = op_mul ? IDX_W'(cfg.a_cols - DIM_W'(1)) : '0;
    assign elem_last = (i_reg == i_last) && (j_reg == j_last);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && (q_data.kind == CMD_RUN)) begin
                    state_next = q_data.ok ? ST_MAC : ST_ERR;
                end
            end
            ST_MAC: begin
                if (k_reg == k_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mul_vld_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = elem_last ? ST_IDLE : ST_MAC;
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and loop counters
    always_comb begin
        q_pop    = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        case (state_reg)
            ST_IDLE: begin
                q_pop  = q_valid;
                i_next = '0;
                j_next = '0;
                k_next = '0;
            end
            ST_MAC: begin
                issue  = 1'b1;
                k_next = (k_reg == k_last) ? '0 : k_reg + IDX_W'(1);
            end
            ST_EMIT: begin
                out_load = slot_free;
                if (slot_free) begin
                    if (j_reg == j_last) begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                    end else begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            ST_ERR: begin
                out_load = slot_free;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign wr_a = q_pop && (q_data.kind == CMD_LOAD_A);
    assign wr_b = q_pop && (q_data.kind == CMD_LOAD_B);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // store addresses: A[i][k] and B[k][j] for a product, A[i][j] and B[i][j] otherwise
    assign addr_a = op_mul ? {i_reg, k_reg} : {i_reg, j_reg};
    assign addr_b = op_mul ? {k_reg, j_reg} : {i_reg, j_reg};

    // element stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[q_data.addr] <= q_data.data;
        end
        rd_a_reg <= mem_a[addr_a];
    end

    always_ff @(posedge aclk) begin
        if (wr_b) begin
            mem_b[q_data.addr] <= q_data.data;
        end
        rd_b_reg <= mem_b[addr_b];
    end

    // term: product, or sum / difference
    assign a_s  = signed'(rd_a_reg);
    assign b_s  = signed'(rd_b_reg);
    assign prod = a_s * b_s;
    assign sum_s = (cfg.operation == OP_SUB) ? ((DATA_W+1)'(a_s) - (DATA_W+1)'(b_s))
                                             : ((DATA_W+1)'(a_s) + (DATA_W+1)'(b_s));
    assign term_next = op_mul ? prod : PROD_W'(sum_s);

    // accumulate, restarting on the first term of an element
    assign acc_next = mul_first_reg ? ACC_W'(term_reg) : acc_reg + ACC_W'(term_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg  <= issue && (k_reg == '0);
        mul_first_reg <= rd_first_reg;
        term_reg      <= term_next;
        if (mul_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    // round, scale and saturate
    assign rounded  = acc_reg + ROUND_C;
    assign scaled   = op_mul ? (rounded >>> FRAC_BITS) : acc_reg;
    assign top_bits = scaled[ACC_W-1:DATA_W-1];
    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            result = scaled[DATA_W-1:0];
        end else begin
            result = scaled[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_word_reg.pad <= '0;
            if (state_reg == ST_ERR) begin
                out_word_reg.out_row   <= '0;
                out_word_reg.out_col   <= '0;
                out_word_reg.out_value <= '0;
                out_error_reg          <= 1'b1;
                out_last_reg           <= 1'b1;
            end else begin
                out_word_reg.out_row   <= POS_W'(i_reg);
                out_word_reg.out_col   <= POS_W'(j_reg);
                out_word_reg.out_value <= result;
                out_error_reg          <= 1'b0;
                out_last_reg           <= elem_last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_word   = out_word_reg;
    assign m_error  = out_error_reg;
    assign m_last   = out_last_reg;

endmodule

// ----- design/matrix_add_sub_multiply.sv -----
// ------------------------------------------------------------------------------------------
// Matrix add / subtract / multiply
// Top level: configuration registers, front end, command queue and engine.
// ------------------------------------------------------------------------------------------
// Elements of A and B (signed Q16.16, up to 8x8 each) are loaded one word at a time; a run
// word then computes A+B, A-B or A*B as set in the operation register and returns the
// result matrix row by row, one word per element, with tlast on the final element. A
// dimension mismatch gives a single word with the error flag and tlast set. Input words
// are taken one per cycle while the four-entry command queue has room; the engine pops the
// queued loads one at a time while idle. A run walks each result element through the
// single multiply-accumulate pipeline: store read, multiply, accumulate, round and
// saturate; a product sums a_cols terms per element, a sum or difference one. Registers
// may only be written while no work is pending.
`include "assert_macros.svh"

module matrix_add_sub_multiply
    import mas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input words
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // row_index[2:0], col_index[5:3], element[37:6]
    input  logic [1:0]         s_tuser,   // action[1:0]
    // result words
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // out_row[2:0], out_col[5:3], out_value[37:6]
    output logic               m_tuser,   // dim_error[0]
    output logic               m_tlast,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t      cfg_reg, cfg_next;
    reg_idx_t  reg_sel;
    logic      reg_wr;

    logic      q_push, q_ready, q_valid, q_pop;
    cmd_t      q_wdata, q_rdata;
    out_word_t m_word;

    // register access
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign reg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (reg_wr) begin
            case (reg_sel)
                REG_OPERATION: cfg_next.operation = op_t'(pwdata[1:0]);
                REG_A_ROWS:    cfg_next.a_rows    = pwdata[DIM_W-1:0];
                REG_A_COLS:    cfg_next.a_cols    = pwdata[DIM_W-1:0];
                REG_B_ROWS:    cfg_next.b_rows    = pwdata[DIM_W-1:0];
                REG_B_COLS:    cfg_next.b_cols    = pwdata[DIM_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.operation <= OP_ADD;
            cfg_reg.a_rows    <= DIM_W'(1);
            cfg_reg.a_cols    <= DIM_W'(1);
            cfg_reg.b_rows    <= DIM_W'(1);
            cfg_reg.b_cols    <= DIM_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb begin
        case (reg_sel)
            REG_OPERATION: prdata = 32'(cfg_reg.operation);
            REG_A_ROWS:    prdata = 32'(cfg_reg.a_rows);
            REG_A_COLS:    prdata = 32'(cfg_reg.a_cols);
            REG_B_ROWS:    prdata = 32'(cfg_reg.b_rows);
            REG_B_COLS:    prdata = 32'(cfg_reg.b_cols);
            default:       prdata = '0;
        endcase
    end

    // front end
    mas_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_word   (in_word_t'(s_tdata)),
        .s_action (action_t'(s_tuser)),
        .cfg      (cfg_reg),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // command queue
    mas_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .ready   (q_ready),
        .valid   (q_valid),
        .rdata   (q_rdata),
        .pop     (q_pop)
    );

    // engine
    mas_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_word   (m_word),
        .m_error  (m_tuser),
        .m_last   (m_tlast)
    );

    assign m_tdata = m_word;

    // checks
    logic [DIM_W-1:0] out_row_ext;
    assign out_row_ext = DIM_W'(m_word.out_row);

    `ASSERT_IMPLIES(a_err_word, m_tvalid && m_tuser, m_tlast && (m_word.out_value == '0),
        "error word without last or with a value")
    `ASSERT_IMPLIES(a_pop_nonempty, q_pop, q_valid, "engine popped an empty queue")
    `ASSERT_IMPLIES(a_row_in_range, m_tvalid && !m_tuser, out_row_ext < cfg_reg.a_rows,
        "result row beyond the row count of A")

endmodule

// ----- test/matrix_add_sub_multiply_test.sv -----
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------
// Matrix add/sub/multiply testbench
// Loads matrices A and B word by word, runs add, subtract and multiply under many register
// settings (valid sizes, mismatched and out-of-range sizes, the unused operation code) and
// checks every result word against a local model of the engine's stores and arithmetic.
// Both streams stall at random; once the receiver holds off long enough to block the input.
// ------------------------------------------------------------------------------------------
module matrix_add_sub_multiply_test;
    import mas_pkg::*;

    localparam int RANDOM_WORDS = 440;
    localparam int CALM_WORDS   = 80;
    localparam int SETTLE       = 32;
    localparam int HOLD_OFF     = 300;
    localparam int WATCHDOG     = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam int PRESSURE_RUN = 2;

    // one row of the directed script: either a register write or an input word
    typedef struct packed {
        logic              is_reg;
        action_t           act;
        reg_idx_t          reg_sel;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              typed;
        logic [DATA_W-1:0] t_value;
        logic              t_err;
    } script_row_t;

    // one result element as it should leave the block
    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              dim_error;
        logic              last;
    } elem_t;

    localparam int SCRIPT_LEN = 38;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // 1x1 add after reset: saturation at the top, then max + min
        '{1'b0, ACT_LOAD_A, REG_OPERATION, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_LOAD_B, REG_OPERATION, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{1'b0, ACT_LOAD_B, REG_OPERATION, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0},
        // subtract: both saturation limits
        '{1'b1, ACT_NONE, REG_OPERATION, 3'd0, 3'd0, 32'(OP_SUB), 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{1'b0, ACT_LOAD_A, REG_OPERATION, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_LOAD_B, REG_OPERATION, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h8000_0000, 1'b0},
        // multiply: negative rounding, min * min saturates, half rounds up
        '{1'b1, ACT_NONE, REG_OPERATION, 3'd0, 3'd0, 32'(OP_MUL), 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_LOAD_B, REG_OPERATION, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{1'b0, ACT_LOAD_A, REG_OPERATION, 3'd0, 3'd0, 32'h0000_8000, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_LOAD_B, REG_OPERATION, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        // unknown action is dropped; loads at the far corner
        '{1'b0, ACT_NONE,   REG_OPERATION, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_LOAD_A, REG_OPERATION, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_LOAD_B, REG_OPERATION, 3'd7, 3'd7, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        // unused operation code
        '{1'b1, ACT_NONE, REG_OPERATION, 3'd0, 3'd0, 32'(OP_BAD), 1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, 1'b1},
        // sizes out of range and mismatched
        '{1'b1, ACT_NONE, REG_OPERATION, 3'd0, 3'd0, 32'(OP_ADD), 1'b0, 32'h0, 1'b0},
        '{1'b1, ACT_NONE, REG_A_ROWS,    3'd0, 3'd0, 32'd0,       1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, 1'b1},
        '{1'b1, ACT_NONE, REG_A_ROWS,    3'd0, 3'd0, 32'd15,      1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, 1'b1},
        '{1'b1, ACT_NONE, REG_A_ROWS,    3'd0, 3'd0, 32'd2,       1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, 1'b1},
        '{1'b1, ACT_NONE, REG_OPERATION, 3'd0, 3'd0, 32'(OP_MUL), 1'b0, 32'h0, 1'b0},
        '{1'b1, ACT_NONE, REG_A_ROWS,    3'd0, 3'd0, 32'd1,       1'b0, 32'h0, 1'b0},
        '{1'b1, ACT_NONE, REG_A_COLS,    3'd0, 3'd0, 32'd2,       1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, 1'b1},
        '{1'b1, ACT_NONE, REG_A_COLS,    3'd0, 3'd0, 32'd1,       1'b0, 32'h0, 1'b0},
        '{1'b1, ACT_NONE, REG_B_ROWS,    3'd0, 3'd0, 32'd9,       1'b0, 32'h0, 1'b0},
        '{1'b0, ACT_RUN,    REG_OPERATION, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, 1'b1},
        '{1'b1, ACT_NONE, REG_B_ROWS,    3'd0, 3'd0, 32'd1,       1'b0, 32'h0, 1'b0},
        '{1'b1, ACT_NONE, REG_B_COLS,    3'd0, 3'd0, 32'd0,       1'b0, 32'h0, 1'b0}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;   // row_index[2:0], col_index[5:3], element[37:6]
    logic [1:0]         s_tuser;   // action[1:0]
    logic               m_tvalid;
    logic               m_tready;
    logic [39:0]        m_tdata;   // out_row[2:0], out_col[5:3], out_value[37:6]
    logic               m_tuser;   // dim_error[0]
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // local copy of the engine: both stores, which entries hold data, and the registers
    logic [DATA_W-1:0] mat_a [STORE_DEPTH];
    logic [DATA_W-1:0] mat_b [STORE_DEPTH];
    bit                a_loaded [STORE_DEPTH];
    bit                b_loaded [STORE_DEPTH];
    op_t               cfg_op;
    logic [DIM_W-1:0]  cfg_ar, cfg_ac, cfg_br, cfg_bc;

    elem_t       due_elems[$];
    int unsigned mismatches;
    int unsigned live_words;
    int unsigned quiet_cycles;
    int unsigned tx_gap_rate;
    bit          calm;
    bit          hold_req;

    matrix_add_sub_multiply u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // watchdog: too long without any word moving on either stream
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit dim_in_range(logic [DIM_W-1:0] d);
        return d >= 1 && d <= MAX_DIM;
    endfunction

    // sizes suit the current operation
    function automatic bit dims_fit();
        if (!(dim_in_range(cfg_ar) && dim_in_range(cfg_ac) &&
              dim_in_range(cfg_br) && dim_in_range(cfg_bc))) begin
            return 1'b0;
        end
        case (cfg_op)
            OP_ADD, OP_SUB: return cfg_ar == cfg_br && cfg_ac == cfg_bc;
            OP_MUL:         return cfg_ac == cfg_br;
            default:        return 1'b0;
        endcase
    endfunction

    // mostly small sizes, now and then the extremes
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return DIM_W'(MAX_DIM);
            1:       return DIM_W'(1);
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Q16.16 values: limits, zero, any pattern, or small magnitudes of either sign
    function automatic logic [DATA_W-1:0] rand_element();
        logic [DATA_W-1:0] mag;
        mag = $urandom_range(0, 32'h0004_0000);
        case ($urandom_range(0, 7))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return $urandom_range(0, 1) ? -mag : mag;
        endcase
    endfunction

    // register write: setup then access, pready always high, idle after
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OPERATION: cfg_op = op_t'(val[1:0]);
            REG_A_ROWS:    cfg_ar = val[DIM_W-1:0];
            REG_A_COLS:    cfg_ac = val[DIM_W-1:0];
            REG_B_ROWS:    cfg_br = val[DIM_W-1:0];
            REG_B_COLS:    cfg_bc = val[DIM_W-1:0];
            default:       ;
        endcase
        @(posedge aclk);
    endtask

    // drop valid, let every expected element arrive, then let queued loads drain
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (due_elems.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // offer one input word; once taken, update the stores and queue the elements it yields
    task automatic send_word(action_t act, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                             logic [DATA_W-1:0] elem, bit typed = 1'b0,
                             logic [DATA_W-1:0] typed_value = '0, logic typed_err = 1'b0);
        int unsigned        slot, n_rows, n_cols, i, j, k;
        logic signed [71:0] acc;
        logic signed [63:0] prod;
        logic signed [33:0] sum;
        logic [DATA_W-1:0]  v;
        elem_t              e;
        if (!calm && tx_gap_rate != 0 && $urandom_range(0, tx_gap_rate) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, elem, col, row};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        if (act != ACT_NONE) live_words++;

        slot = row * MAX_DIM + col;
        case (act)
            ACT_LOAD_A: begin
                mat_a[slot]    = elem;
                a_loaded[slot] = 1'b1;
            end
            ACT_LOAD_B: begin
                mat_b[slot]    = elem;
                b_loaded[slot] = 1'b1;
            end
            ACT_RUN: begin
                if (typed) begin
                    e = '{row: '0, col: '0, value: typed_value, dim_error: typed_err,
                          last: 1'b1};
                    due_elems.push_back(e);
                end else if (!dims_fit()) begin
                    e = '{row: '0, col: '0, value: '0, dim_error: 1'b1, last: 1'b1};
                    due_elems.push_back(e);
                end else begin
                    n_rows = 32'(cfg_ar);
                    n_cols = (cfg_op == OP_MUL) ? 32'(cfg_bc) : 32'(cfg_ac);
                    for (i = 0; i < n_rows; i++) begin
                        for (j = 0; j < n_cols; j++) begin
                            if (cfg_op == OP_MUL) begin
                                // exact sum of products, round half up, then saturate
                                acc = '0;
                                for (k = 0; k < cfg_ac; k++) begin
                                    prod = $signed(mat_a[i * MAX_DIM + k]) *
                                           $signed(mat_b[k * MAX_DIM + j]);
                                    acc  = acc + prod;
                                end
                                if (FRAC_BITS > 0) acc = acc + (72'sd1 <<< (FRAC_BITS - 1));
                                acc = acc >>> FRAC_BITS;
                                if (acc > 72'sd2147483647) v = SAT_MAX;
                                else if (acc < -72'sd2147483648) v = SAT_MIN;
                                else v = acc[DATA_W-1:0];
                            end else begin
                                if (cfg_op == OP_ADD) begin
                                    sum = $signed(mat_a[i * MAX_DIM + j]) +
                                          $signed(mat_b[i * MAX_DIM + j]);
                                end else begin
                                    sum = $signed(mat_a[i * MAX_DIM + j]) -
                                          $signed(mat_b[i * MAX_DIM + j]);
                                end
                                if (sum > 34'sd2147483647) v = SAT_MAX;
                                else if (sum < -34'sd2147483648) v = SAT_MIN;
                                else v = sum[DATA_W-1:0];
                            end
                            e = '{row: i[POS_W-1:0], col: j[POS_W-1:0], value: v,
                                  dim_error: 1'b0,
                                  last: (i + 1 == n_rows) && (j + 1 == n_cols)};
                            due_elems.push_back(e);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // result side: check each word taken, then decide tready for the next edge
    initial begin : drain_results
        int unsigned stall_left, hold_left, rate_age, rx_rate;
        elem_t       want;
        logic        next_ready;
        stall_left = 0;
        hold_left  = 0;
        rate_age   = 0;
        rx_rate    = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (due_elems.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected word: row %0d col %0d value %h err %b last %b",
                                 m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tuser, m_tlast);
                    end
                end else begin
                    want = due_elems.pop_front();
                    if (m_tdata[2:0] !== want.row || m_tdata[5:3] !== want.col ||
                        m_tdata[37:6] !== want.value || m_tuser !== want.dim_error ||
                        m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch: expected row %0d col %0d value %h err %b last %b",
                                     want.row, want.col, want.value, want.dim_error, want.last);
                            $display("          got      row %0d col %0d value %h err %b last %b",
                                     m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tuser,
                                     m_tlast);
                        end
                    end
                end
            end

            // stall pattern changes every so often, including stretches with none
            if (rate_age == 0) begin
                rate_age = 128;
                case ($urandom_range(0, 2))
                    0:       rx_rate = 0;
                    1:       rx_rate = 3;
                    default: rx_rate = 10;
                endcase
            end else begin
                rate_age--;
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF;
            end

            if (hold_left != 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!calm && rx_rate != 0 && $urandom_range(0, rx_rate) == 0) begin
                stall_left = $urandom_range(0, 4);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            m_tready <= next_ready;
        end
    end

    // stimulus: directed script, then random phases of register setting, loads and runs
    initial begin : feed_words
        int unsigned       n, start, phase, runs, extra, r, i, j;
        op_t               op;
        logic [DIM_W-1:0]  ar, ac, br, bc;
        logic [31:0]       junk;
        action_t           act;

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_LOAD_A;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        cfg_op = OP_ADD;
        cfg_ar = DIM_W'(1);
        cfg_ac = DIM_W'(1);
        cfg_br = DIM_W'(1);
        cfg_bc = DIM_W'(1);
        for (n = 0; n < STORE_DEPTH; n++) begin
            mat_a[n]    = '0;
            mat_b[n]    = '0;
            a_loaded[n] = 1'b0;
            b_loaded[n] = 1'b0;
        end
        mismatches  = 0;
        live_words  = 0;
        tx_gap_rate = 4;
        calm        = 1'b0;
        hold_req    = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed script
        for (n = 0; n < SCRIPT_LEN; n++) begin
            if (SCRIPT[n].is_reg) begin
                wait_quiet();
                write_reg(SCRIPT[n].reg_sel, SCRIPT[n].value);
            end else begin
                send_word(SCRIPT[n].act, SCRIPT[n].row, SCRIPT[n].col, SCRIPT[n].value,
                          SCRIPT[n].typed, SCRIPT[n].t_value, SCRIPT[n].t_err);
            end
        end

        // random phases
        start = live_words;
        phase = 0;
        while (live_words - start < RANDOM_WORDS) begin
            wait_quiet();
            calm = (live_words - start >= RANDOM_WORDS - CALM_WORDS);
            case ($urandom_range(0, 2))
                0:       tx_gap_rate = 0;
                1:       tx_gap_rate = 3;
                default: tx_gap_rate = 10;
            endcase

            // mostly sizes that suit the operation, sometimes anything the fields allow
            if ($urandom_range(0, 4) != 0) begin
                op = op_t'($urandom_range(0, 2));
                ar = pick_dim();
                ac = pick_dim();
                if (op == OP_MUL) begin
                    br = ac;
                    bc = pick_dim();
                end else begin
                    br = ar;
                    bc = ac;
                end
            end else begin
                op = op_t'($urandom_range(0, 3));
                ar = DIM_W'($urandom_range(0, 15));
                ac = DIM_W'($urandom_range(0, 15));
                br = DIM_W'($urandom_range(0, 15));
                bc = DIM_W'($urandom_range(0, 15));
            end
            junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
            write_reg(REG_OPERATION, {junk[31:2], op});
            write_reg(REG_A_ROWS, {junk[31:4], ar});
            write_reg(REG_A_COLS, {junk[31:4], ac});
            write_reg(REG_B_ROWS, {junk[31:4], br});
            write_reg(REG_B_COLS, {junk[31:4], bc});

            // fill what the run reads; never read an entry that was not loaded
            if (dims_fit()) begin
                for (i = 0; i < cfg_ar; i++) begin
                    for (j = 0; j < cfg_ac; j++) begin
                        if (!a_loaded[i * MAX_DIM + j] || $urandom_range(0, 3) == 0) begin
                            send_word(ACT_LOAD_A, i[POS_W-1:0], j[POS_W-1:0], rand_element());
                        end
                        if ($urandom_range(0, 9) == 0) begin
                            send_word(action_t'($urandom_range(0, 3)), POS_W'($urandom),
                                      POS_W'($urandom), rand_element());
                        end
                    end
                end
                for (i = 0; i < cfg_br; i++) begin
                    for (j = 0; j < cfg_bc; j++) begin
                        if (!b_loaded[i * MAX_DIM + j] || $urandom_range(0, 3) == 0) begin
                            send_word(ACT_LOAD_B, i[POS_W-1:0], j[POS_W-1:0], rand_element());
                        end
                    end
                end
            end

            // the receiver holds off from the first run on, so two runs back up the queue
            if (phase == PRESSURE_RUN) hold_req = 1'b1;

            // runs, with a few reloads of data the run reads in between
            runs = (phase == PRESSURE_RUN) ? 2 : $urandom_range(1, 3);
            for (r = 0; r < runs; r++) begin
                send_word(ACT_RUN, POS_W'($urandom), POS_W'($urandom), $urandom);
                extra = dims_fit() ? $urandom_range(0, 3) : 0;
                for (n = 0; n < extra; n++) begin
                    act = $urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A;
                    if (act == ACT_LOAD_A) begin
                        i = $urandom_range(0, cfg_ar - 1);
                        j = $urandom_range(0, cfg_ac - 1);
                    end else begin
                        i = $urandom_range(0, cfg_br - 1);
                        j = $urandom_range(0, cfg_bc - 1);
                    end
                    send_word(act, i[POS_W-1:0], j[POS_W-1:0], rand_element());
                end
            end

            // trailing words anywhere; enough of them to fill the queue under the hold-off
            extra = (phase == PRESSURE_RUN) ? 12 : $urandom_range(0, 4);
            for (n = 0; n < extra; n++) begin
                send_word(action_t'($urandom_range(0, 3)), POS_W'($urandom), POS_W'($urandom),
                          rand_element());
            end
            phase++;
        end

        wait_quiet();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/mas_pkg.sv
design/mas_front.sv
design/mas_queue.sv
design/mas_engine.sv
design/matrix_add_sub_multiply.sv
test/matrix_add_sub_multiply_test.sv
